### src/rpn_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the character decoder for the RPN calculator.
// Used by every module of the block; depends on nothing else.

package rpn_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_EQUAL   = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_QUIT    = 8'h71;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QUIT      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd5;

    typedef enum logic [3:0] {
        CLS_DIGIT,
        CLS_ADD,
        CLS_SUB,
        CLS_MUL,
        CLS_DIV,
        CLS_EQ,
        CLS_SPACE,
        CLS_NEWLINE,
        CLS_QUIT,
        CLS_INVALID
    } char_class_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load_char;
        logic                rd_top;
        logic                rd_second;
        logic                cap_rhs;
        logic                cap_lhs;
        logic                push_digit;
        logic                push_alu;
        logic                pop_eq;
        logic                pop_two;
        logic                clear_stack;
        logic                set_status;
        logic [STATUS_W-1:0] status_code;
        logic                div_start;
        logic                out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        char_class_t cls;
        logic        full;
        logic        lt2;
        logic        empty;
        logic        rhs_zero;
        logic        div_done;
        logic        out_free;
    } dp_status_t;

    function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
        char_class_t cls;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            cls = CLS_DIGIT;
        end else if (c == CH_PLUS) begin
            cls = CLS_ADD;
        end else if (c == CH_MINUS) begin
            cls = CLS_SUB;
        end else if (c == CH_STAR) begin
            cls = CLS_MUL;
        end else if (c == CH_SLASH) begin
            cls = CLS_DIV;
        end else if (c == CH_EQUAL) begin
            cls = CLS_EQ;
        end else if (c == CH_SPACE) begin
            cls = CLS_SPACE;
        end else if (c == CH_NEWLINE) begin
            cls = CLS_NEWLINE;
        end else if (c == CH_QUIT) begin
            cls = CLS_QUIT;
        end else begin
            cls = CLS_INVALID;
        end
        return cls;
    endfunction

endpackage

### src/rpn_div.sv
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg for widths.

module rpn_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [rpn_pkg::DATA_W-1:0] dividend,
    input  logic signed [rpn_pkg::DATA_W-1:0] divisor,
    output logic                             done,
    output logic        [rpn_pkg::DATA_W-1:0] quotient
);

    logic [rpn_pkg::DATA_W-1:0]    rem_reg, rem_next;
    logic [rpn_pkg::DATA_W-1:0]    quo_reg, quo_next;
    logic [rpn_pkg::DATA_W-1:0]    den_reg;
    logic                          neg_reg;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [rpn_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [rpn_pkg::DATA_W:0]      shifted;
    logic                          ge;
    logic [rpn_pkg::DATA_W-1:0]    diff;
    logic [rpn_pkg::DATA_W-1:0]    a_mag, b_mag;

    assign a_mag   = dividend[rpn_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
    assign b_mag   = divisor[rpn_pkg::DATA_W-1] ? (~divisor + 1'b1) : divisor;
    assign shifted = {rem_reg, quo_reg[rpn_pkg::DATA_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    // When the subtraction is taken its result is below the divisor, so the
    // low bits alone carry it.
    assign diff    = shifted[rpn_pkg::DATA_W-1:0] - den_reg;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = a_mag;
            busy_next = 1'b1;
            cnt_next  = rpn_pkg::DIV_CNT_W'(rpn_pkg::DIV_STEPS);
        end else if (busy_reg) begin
            // Restoring step: the remainder always stays below the divisor magnitude.
            rem_next = ge ? diff : shifted[rpn_pkg::DATA_W-1:0];
            quo_next = {quo_reg[rpn_pkg::DATA_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rpn_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            den_reg <= b_mag;
            neg_reg <= dividend[rpn_pkg::DATA_W-1] ^ divisor[rpn_pkg::DATA_W-1];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

### src/rpn_dpath.sv
`timescale 1ns / 1ps
// Datapath: operand stack memory, stack count, operand registers, ALU,
// pending result and output register. Depends on rpn_pkg and rpn_div.

module rpn_dpath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rpn_pkg::dp_cmd_t                   cmd,
    output rpn_pkg::dp_status_t                status,
    input  logic        [rpn_pkg::CHAR_W-1:0]  s_char_code,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [rpn_pkg::DATA_W-1:0]  m_result_value,
    output logic                               m_result_valid,
    output logic        [rpn_pkg::STATUS_W-1:0] m_status
);

    logic [rpn_pkg::DATA_W-1:0]   stack_mem [rpn_pkg::STACK_DEPTH];
    logic [rpn_pkg::DATA_W-1:0]   rd_data_reg;
    logic [rpn_pkg::CHAR_W-1:0]   char_reg;
    logic [rpn_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [rpn_pkg::CNT_W-1:0]    cnt_m1, cnt_m2;
    logic [rpn_pkg::DATA_W-1:0]   lhs_reg, rhs_reg;
    logic [rpn_pkg::DATA_W-1:0]   pend_value_reg;
    logic                         pend_valid_reg;
    logic [rpn_pkg::STATUS_W-1:0] pend_status_reg;
    logic [rpn_pkg::DATA_W-1:0]   out_value_reg;
    logic                         out_valid_reg;
    logic [rpn_pkg::STATUS_W-1:0] out_status_reg;
    logic                         m_valid_reg, m_valid_next;
    logic [rpn_pkg::PTR_W-1:0]    rd_addr, wr_addr;
    logic                         rd_en, wr_en;
    logic [rpn_pkg::DATA_W-1:0]   wr_data;
    logic [rpn_pkg::DATA_W-1:0]   alu_res;
    logic [rpn_pkg::DATA_W-1:0]   product;
    logic [rpn_pkg::DATA_W-1:0]   digit_val;
    logic                         div_done;
    logic [rpn_pkg::DATA_W-1:0]   div_q;
    rpn_pkg::char_class_t         cls;

    assign cls       = rpn_pkg::classify(char_reg);
    assign cnt_m1    = count_reg - rpn_pkg::CNT_W'(1);
    assign cnt_m2    = count_reg - rpn_pkg::CNT_W'(2);
    assign digit_val = rpn_pkg::DATA_W'(char_reg - rpn_pkg::CH_ZERO);
    // Only the low word of the product is kept, as the result wraps.
    assign product   = lhs_reg * rhs_reg;

    rpn_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (lhs_reg),
        .divisor  (rhs_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        case (cls)
            rpn_pkg::CLS_ADD: alu_res = lhs_reg + rhs_reg;
            rpn_pkg::CLS_SUB: alu_res = lhs_reg - rhs_reg;
            rpn_pkg::CLS_MUL: alu_res = product;
            rpn_pkg::CLS_DIV: alu_res = div_q;
            default:          alu_res = '0;
        endcase
    end

    assign rd_en   = cmd.rd_top | cmd.rd_second;
    assign rd_addr = cmd.rd_second ? cnt_m2[rpn_pkg::PTR_W-1:0] : cnt_m1[rpn_pkg::PTR_W-1:0];
    assign wr_en   = cmd.push_digit | cmd.push_alu;
    assign wr_addr = cmd.push_alu ? cnt_m2[rpn_pkg::PTR_W-1:0] : count_reg[rpn_pkg::PTR_W-1:0];
    assign wr_data = cmd.push_alu ? alu_res : digit_val;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.clear_stack) begin
            count_next = '0;
        end else if (cmd.push_digit) begin
            count_next = count_reg + rpn_pkg::CNT_W'(1);
        end else if (cmd.push_alu || cmd.pop_eq) begin
            count_next = cnt_m1;
        end else if (cmd.pop_two) begin
            count_next = cnt_m2;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_char) begin
            char_reg        <= s_char_code;
            pend_value_reg  <= '0;
            pend_valid_reg  <= 1'b0;
            pend_status_reg <= rpn_pkg::ST_OK;
        end
        if (cmd.set_status) begin
            pend_status_reg <= cmd.status_code;
        end
        if (cmd.pop_eq) begin
            pend_value_reg <= rd_data_reg;
            pend_valid_reg <= 1'b1;
        end
        if (cmd.cap_rhs) begin
            rhs_reg <= rd_data_reg;
        end
        if (cmd.cap_lhs) begin
            lhs_reg <= rd_data_reg;
        end
        if (cmd.out_load) begin
            out_value_reg  <= pend_value_reg;
            out_valid_reg  <= pend_valid_reg;
            out_status_reg <= pend_status_reg;
        end
    end

    always_comb begin
        status          = '0;
        status.cls      = cls;
        status.full     = count_reg >= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH);
        status.lt2      = count_reg < rpn_pkg::CNT_W'(2);
        status.empty    = count_reg == '0;
        status.rhs_zero = rhs_reg == '0;
        status.div_done = div_done;
        status.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = out_value_reg;
    assign m_result_valid = out_valid_reg;
    assign m_status       = out_status_reg;

endmodule

### src/rpn_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences stack reads, ALU and divider steps and
// the hand-off of each result to the output register. Depends on rpn_pkg.

module rpn_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rpn_pkg::dp_status_t status,
    output rpn_pkg::dp_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_RD1    = 7'b0000100,
        S_RD2    = 7'b0001000,
        S_EXEC   = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_RESP   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_char = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_RESP;
                case (status.cls)
                    rpn_pkg::CLS_DIGIT: begin
                        if (status.full) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = rpn_pkg::ST_OVERFLOW;
                        end else begin
                            cmd.push_digit = 1'b1;
                        end
                    end
                    rpn_pkg::CLS_ADD, rpn_pkg::CLS_SUB,
                    rpn_pkg::CLS_MUL, rpn_pkg::CLS_DIV: begin
                        if (status.lt2) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = rpn_pkg::ST_UNDERFLOW;
                        end else begin
                            cmd.rd_top = 1'b1;
                            state_next = S_RD1;
                        end
                    end
                    rpn_pkg::CLS_EQ: begin
                        if (status.empty) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = rpn_pkg::ST_UNDERFLOW;
                        end else begin
                            cmd.rd_top = 1'b1;
                            state_next = S_RD1;
                        end
                    end
                    rpn_pkg::CLS_SPACE: begin
                        cmd.clear_stack = 1'b0;
                    end
                    rpn_pkg::CLS_NEWLINE: begin
                        cmd.clear_stack = 1'b1;
                    end
                    rpn_pkg::CLS_QUIT: begin
                        cmd.clear_stack = 1'b1;
                        cmd.set_status  = 1'b1;
                        cmd.status_code = rpn_pkg::ST_QUIT;
                    end
                    default: begin
                        cmd.clear_stack = 1'b1;
                        cmd.set_status  = 1'b1;
                        cmd.status_code = rpn_pkg::ST_INVALID;
                    end
                endcase
            end
            S_RD1: begin
                // The top entry is in the read register now.
                if (status.cls == rpn_pkg::CLS_EQ) begin
                    cmd.pop_eq = 1'b1;
                    state_next = S_RESP;
                end else begin
                    cmd.cap_rhs   = 1'b1;
                    cmd.rd_second = 1'b1;
                    state_next    = S_RD2;
                end
            end
            S_RD2: begin
                cmd.cap_lhs = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC: begin
                if (status.cls == rpn_pkg::CLS_DIV) begin
                    if (status.rhs_zero) begin
                        cmd.pop_two     = 1'b1;
                        cmd.set_status  = 1'b1;
                        cmd.status_code = rpn_pkg::ST_DIVZERO;
                        state_next      = S_RESP;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end else begin
                    cmd.push_alu = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_DIV: begin
                if (status.div_done) begin
                    cmd.push_alu = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_RESP: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### src/rpn_stack_calculator.sv
`timescale 1ns / 1ps
// Reverse Polish integer calculator on a 32-entry operand stack.
// Input channel (s_valid/s_ready/s_char_code) takes one ASCII character per
// request. Output channel (m_valid/m_ready and the m_ payload) returns exactly
// one result per character: the popped value on '=', and a status code.
// Digits, space, newline, 'q' and other characters go straight from decode to
// the response; '=' first reads the top entry; + - * and a division by zero
// read both operands and then execute; a division then waits for the radix-2
// divider, which retires one quotient bit per cycle. One request is in flight
// at a time, and the next character can be accepted at the first edge at which
// the result of the last one can be taken.
// The stack memory has one read port, so the two operands of an operator are
// read in consecutive cycles.
// Reset (aresetn low, synchronous) empties the stack and drops any pending
// result; stack contents are not cleared since only held entries are read.
// When the receiver stalls, the result stays in the output register and the
// block still accepts the next character, but holds its own result until the
// output register frees up.
// Depends on rpn_pkg, rpn_ctrl and rpn_dpath.

module rpn_stack_calculator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic        [rpn_pkg::CHAR_W-1:0]   s_char_code,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [rpn_pkg::DATA_W-1:0]   m_result_value,
    output logic                                m_result_valid,
    output logic        [rpn_pkg::STATUS_W-1:0] m_status
);

    rpn_pkg::dp_cmd_t    cmd;
    rpn_pkg::dp_status_t status;

    rpn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rpn_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_char_code    (s_char_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_result_valid (m_result_valid),
        .m_status       (m_status)
    );

endmodule
